// ===== rtl/pfdrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdrc_pkg
// shared types and constants of the packet store with duplicate check and
// destination/time range count
// ----------------------------------------------------------------------------
package pfdrc_pkg;

  localparam int DEPTH_DEFAULT = 256;

  localparam int ID_W    = 20;
  localparam int TS_W    = 30;
  localparam int LIMIT_W = 9;
  localparam int CNT_W   = 9;
  localparam int REQ_W   = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FWD   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COUNT = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [ID_W-1:0]  source;
    logic [ID_W-1:0]  destination;
    logic [TS_W-1:0]  timestamp;
    logic [TS_W-1:0]  start_time;
    logic [TS_W-1:0]  end_time;
  } req_t;

  typedef struct packed {
    logic             accepted;
    logic             packet_valid;
    logic [ID_W-1:0]  out_source;
    logic [ID_W-1:0]  out_destination;
    logic [TS_W-1:0]  out_timestamp;
    logic [CNT_W-1:0] match_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture request, rewind scan pointer to head
    logic issue;   // read next stored entry of the scan
    logic fwd_rd;  // read the head entry
    logic commit;  // append the add unless a duplicate was found
    logic emit;    // load the result register, pop on forward
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic rd_pend;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/pfdrc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdrc_ctrl
// request sequencer: accept, scan, commit and hand over the result
// ----------------------------------------------------------------------------
module pfdrc_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  logic [pfdrc_pkg::REQ_W-1:0] req_type,
  output logic                      req_stall,
  input  pfdrc_pkg::status_t        status,
  output pfdrc_pkg::cmd_t           cmd
);
  import pfdrc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_ADD,
    ST_SCAN_CNT,
    ST_COMMIT,
    ST_FWD,
    ST_RESULT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = req_valid && !req_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          case (req_type)
            REQ_ADD:   state_next = ST_SCAN_ADD;
            REQ_COUNT: state_next = ST_SCAN_CNT;
            REQ_FWD:   state_next = ST_FWD;
            default:   state_next = ST_RESULT;
          endcase
        end
      end
      ST_SCAN_ADD, ST_SCAN_CNT: begin
        cmd.issue = !status.scan_done;
        if (status.scan_done && !status.rd_pend) begin
          state_next = (state == ST_SCAN_ADD) ? ST_COMMIT : ST_RESULT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_RESULT;
      end
      ST_FWD: begin
        cmd.fwd_rd = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      req_stall <= 1'b0;
    end else begin
      state     <= state_next;
      req_stall <= (state_next != ST_IDLE);
    end
  end

  // only one datapath operation per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.issue, cmd.fwd_rd, cmd.commit, cmd.emit}))
    else $error("more than one datapath command at once");

  // an accepted item closes the input until its result is handed over
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> req_stall)
    else $error("input open while an item is in progress");

  a_emit_reopens: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> !req_stall)
    else $error("input still stalled after result handed over");

endmodule

// ===== rtl/pfdrc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdrc_dp
// packet memory, ring pointers, scan compare and result register
// ----------------------------------------------------------------------------
module pfdrc_dp #(
  parameter int DEPTH = pfdrc_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pfdrc_pkg::req_t               req,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [pfdrc_pkg::LIMIT_W-1:0] cfg_data,
  input  pfdrc_pkg::cmd_t               cmd,
  output pfdrc_pkg::status_t            status,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output pfdrc_pkg::rsp_t               rsp
);
  import pfdrc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW = $clog2(DEPTH + 1);
  localparam int LW = (OW > LIMIT_W) ? OW : LIMIT_W;
  localparam int EW = 2 * ID_W + TS_W;

  typedef struct packed {
    logic [ID_W-1:0] src;
    logic [ID_W-1:0] dst;
    logic [TS_W-1:0] ts;
  } entry_t;

  logic [EW-1:0]      mem [DEPTH];
  entry_t             rd_data;
  entry_t             wr_entry;
  logic               rd_en;
  logic               wr_en;

  logic [LIMIT_W-1:0] memory_limit;
  logic [AW-1:0]      head;
  logic [OW-1:0]      occ;
  logic [AW-1:0]      rd_ptr;
  logic [OW-1:0]      scan_cnt;
  logic               rd_pend;
  logic               dup;
  logic [CNT_W-1:0]   count;
  req_t               cap;

  logic [LW-1:0]      lim_ext;
  logic [LW-1:0]      eff_limit;
  logic               evict;
  logic               hit_add;
  logic               hit_cnt;
  logic [AW-1:0]      head_inc;
  logic [AW-1:0]      rd_ptr_inc;
  logic               out_free;
  rsp_t               rsp_next;

  // effective limit: zero acts as one, above DEPTH acts as DEPTH
  always_comb begin
    lim_ext = LW'(memory_limit);
    if (lim_ext == '0) begin
      eff_limit = LW'(1);
    end else if (lim_ext > LW'(DEPTH)) begin
      eff_limit = LW'(DEPTH);
    end else begin
      eff_limit = lim_ext;
    end
  end

  assign evict      = LW'(occ) >= eff_limit;
  assign head_inc   = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign rd_ptr_inc = (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  assign hit_add = (rd_data.src == cap.source) && (rd_data.dst == cap.destination) &&
                   (rd_data.ts == cap.timestamp);
  assign hit_cnt = (rd_data.dst == cap.destination) &&
                   (rd_data.ts >= cap.start_time) && (rd_data.ts <= cap.end_time);

  assign rd_en    = cmd.issue || cmd.fwd_rd;
  assign wr_en    = cmd.commit && !dup;
  assign wr_entry = '{src: cap.source, dst: cap.destination, ts: cap.timestamp};

  // after a full scan rd_ptr sits on the tail slot, which is the write slot
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[rd_ptr] <= wr_entry;
    end
    if (rd_en) begin
      rd_data <= mem[rd_ptr];
    end
  end

  assign out_free = !rsp_valid || !rsp_stall;

  assign status.scan_done = (scan_cnt == occ);
  assign status.rd_pend   = rd_pend;
  assign status.out_free  = out_free;

  always_comb begin
    rsp_next = '0;
    case (cap.req_type)
      REQ_ADD:   rsp_next.accepted = !dup;
      REQ_FWD: begin
        if (occ != '0) begin
          rsp_next.packet_valid    = 1'b1;
          rsp_next.out_source      = rd_data.src;
          rsp_next.out_destination = rd_data.dst;
          rsp_next.out_timestamp   = rd_data.ts;
        end
      end
      REQ_COUNT: rsp_next.match_count = count;
      default:   rsp_next = '0;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cap <= req;
    end
    if (cmd.emit) begin
      rsp <= rsp_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      memory_limit <= LIMIT_RESET;
      head         <= '0;
      occ          <= '0;
      rd_ptr       <= '0;
      scan_cnt     <= '0;
      rd_pend      <= 1'b0;
      dup          <= 1'b0;
      count        <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        memory_limit <= cfg_data;
      end

      rd_pend <= cmd.issue;
      if (rd_pend) begin
        if (hit_add) begin
          dup <= 1'b1;
        end
        if (hit_cnt) begin
          count <= count + 1'b1;
        end
      end

      if (cmd.load) begin
        rd_ptr   <= head;
        scan_cnt <= '0;
        dup      <= 1'b0;
        count    <= '0;
        rd_pend  <= 1'b0;
      end else if (cmd.issue) begin
        rd_ptr   <= rd_ptr_inc;
        scan_cnt <= scan_cnt + 1'b1;
      end

      if (wr_en) begin
        if (evict) begin
          head <= head_inc;
        end else begin
          occ <= occ + 1'b1;
        end
      end

      if (cmd.emit && cap.req_type == REQ_FWD && occ != '0) begin
        head <= head_inc;
        occ  <= occ - 1'b1;
      end

      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OW'(DEPTH))
    else $error("occupancy above depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    scan_cnt <= occ)
    else $error("scan ran past the stored entries");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result register overwritten while held");

  a_occ_only_on_update: assert property (@(posedge clk) disable iff (rst)
    !(cmd.commit || cmd.emit) |=> occ == $past(occ))
    else $error("occupancy moved outside commit or pop");

endmodule

// ===== rtl/packet_fifo_dedup_range_count_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_fifo_dedup_range_count_top
// bounded ring store of packets with duplicate refusal on add, pop on
// forward and a destination / time window count
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload          direction
//  -------   ---------------------   --------------   ---------
//  req       req_valid / req_stall   req   (req_t)    in
//  rsp       rsp_valid / rsp_stall   rsp   (rsp_t)    out
//  cfg       cfg_valid / cfg_ready   cfg_data (9 b)   in
//
// - add and count scan all stored entries before the result is ready; the
//   scan reads one stored entry per cycle through the single memory port
// - forward needs no scan, and the unused request code goes straight to the
//   result state
// - one item in flight at a time; req_stall is high from accept until the
//   result is loaded into the output register, which then waits on rsp_stall
//   while the next item may already be accepted
// - synchronous reset empties the store and sets the limit to 256; the
//   packet memory itself is not cleared, only occupied slots are ever read
// - cfg_ready is always high; the limit is expected to change only when idle
//
module packet_fifo_dedup_range_count_top #(
  parameter int DEPTH = pfdrc_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          req_valid,
  output logic                          req_stall,
  input  pfdrc_pkg::req_t               req,
  // result channel
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output pfdrc_pkg::rsp_t               rsp,
  // limit register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfdrc_pkg::LIMIT_W-1:0] cfg_data
);
  import pfdrc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // limit write is never blocked
  assign cfg_ready = 1'b1;

  // sequencer: one state per phase of a request
  pfdrc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req.req_type),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // packet ring, scan compare and output register
  pfdrc_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
